// ===== rtl/core/ig3d_pkg.sv =====
// Package for the isotropic gradient block: payload types, stencil table,
// weights, register indexes and controller states. No dependencies.
package ig3d_pkg;

    localparam int DimX = 32;
    localparam int DimY = 32;
    localparam int DimZ = 32;
    localparam int XW = $clog2(DimX);
    localparam int YW = $clog2(DimY);
    localparam int ZW = $clog2(DimZ);
    localparam int AddrW = XW + YW + ZW;
    localparam int Depth = DimX * DimY * DimZ;
    localparam int AccW = 64;
    localparam int E4Count = 18;
    localparam int E6Count = 32;

    localparam logic [2:0] RegSizeX = 3'd0;
    localparam logic [2:0] RegSizeY = 3'd1;
    localparam logic [2:0] RegSizeZ = 3'd2;
    localparam logic [2:0] RegStencil = 3'd3;
    localparam logic [2:0] RegBoundary = 3'd4;

    localparam logic OpWrite = 1'b0;
    localparam logic OpQuery = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic signed [31:0] cell_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] gradient_x;
        logic signed [31:0] gradient_y;
        logic signed [31:0] gradient_z;
    } out_item_t;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
        logic signed [2:0] dz;
        logic [1:0]        shell;
    } offset_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ADDR,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic issue;
        logic acc;
        logic clear;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

    function automatic offset_t stencil_offset(input logic [4:0] p);
        offset_t o;
        unique case (p)
            5'd0:  o = '{3'sd1, 3'sd0, 3'sd0, 2'd0};
            5'd1:  o = '{-3'sd1, 3'sd0, 3'sd0, 2'd0};
            5'd2:  o = '{3'sd0, 3'sd1, 3'sd0, 2'd0};
            5'd3:  o = '{3'sd0, -3'sd1, 3'sd0, 2'd0};
            5'd4:  o = '{3'sd0, 3'sd0, 3'sd1, 2'd0};
            5'd5:  o = '{3'sd0, 3'sd0, -3'sd1, 2'd0};
            5'd6:  o = '{3'sd1, 3'sd1, 3'sd0, 2'd1};
            5'd7:  o = '{3'sd1, -3'sd1, 3'sd0, 2'd1};
            5'd8:  o = '{-3'sd1, 3'sd1, 3'sd0, 2'd1};
            5'd9:  o = '{-3'sd1, -3'sd1, 3'sd0, 2'd1};
            5'd10: o = '{3'sd1, 3'sd0, 3'sd1, 2'd1};
            5'd11: o = '{3'sd1, 3'sd0, -3'sd1, 2'd1};
            5'd12: o = '{-3'sd1, 3'sd0, 3'sd1, 2'd1};
            5'd13: o = '{-3'sd1, 3'sd0, -3'sd1, 2'd1};
            5'd14: o = '{3'sd0, 3'sd1, 3'sd1, 2'd1};
            5'd15: o = '{3'sd0, 3'sd1, -3'sd1, 2'd1};
            5'd16: o = '{3'sd0, -3'sd1, 3'sd1, 2'd1};
            5'd17: o = '{3'sd0, -3'sd1, -3'sd1, 2'd1};
            5'd18: o = '{3'sd1, 3'sd1, 3'sd1, 2'd2};
            5'd19: o = '{3'sd1, 3'sd1, -3'sd1, 2'd2};
            5'd20: o = '{3'sd1, -3'sd1, 3'sd1, 2'd2};
            5'd21: o = '{3'sd1, -3'sd1, -3'sd1, 2'd2};
            5'd22: o = '{-3'sd1, 3'sd1, 3'sd1, 2'd2};
            5'd23: o = '{-3'sd1, 3'sd1, -3'sd1, 2'd2};
            5'd24: o = '{-3'sd1, -3'sd1, 3'sd1, 2'd2};
            5'd25: o = '{-3'sd1, -3'sd1, -3'sd1, 2'd2};
            5'd26: o = '{3'sd2, 3'sd0, 3'sd0, 2'd3};
            5'd27: o = '{-3'sd2, 3'sd0, 3'sd0, 2'd3};
            5'd28: o = '{3'sd0, 3'sd2, 3'sd0, 2'd3};
            5'd29: o = '{3'sd0, -3'sd2, 3'sd0, 2'd3};
            5'd30: o = '{3'sd0, 3'sd0, 3'sd2, 2'd3};
            default: o = '{3'sd0, 3'sd0, -3'sd2, 2'd3};
        endcase
        return o;
    endfunction

    function automatic logic [22:0] shell_weight(input logic e6, input logic [1:0] s);
        logic [22:0] w;
        unique case ({e6, s})
            3'b000:  w = 23'd2796203;
            3'b001:  w = 23'd1398101;
            3'b100:  w = 23'd2236962;
            3'b101:  w = 23'd1118481;
            3'b110:  w = 23'd279620;
            3'b111:  w = 23'd139810;
            default: w = 23'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/ig3d_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ig3d_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/ig3d_ctrl.sv =====
// Controller for the gradient block: loads write items and sequences stencil offsets of a query.
// Depends on ig3d_pkg.
module ig3d_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             operation,
    input  ig3d_pkg::stat_t  stat,
    output ig3d_pkg::cmd_t   cmd,
    output logic             busy
);
    import ig3d_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.load = start;
                if (start && operation == OpQuery)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.issue = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = stat.last ? ST_DONE : ST_ADDR;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("finish not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc && !stat.last |=> cmd.issue)
        else $error("offset sequence broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OpQuery |=> cmd.prep)
        else $error("query not started");
endmodule

// ===== rtl/core/ig3d_datapath.sv =====
// Datapath: field store, neighbor addressing, weighted accumulation, rounding.
// Depends on ig3d_pkg and ig3d_ram.
module ig3d_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ig3d_pkg::cmd_t      cmd,
    input  ig3d_pkg::in_item_t  item,
    input  logic [5:0]          size_x,
    input  logic [5:0]          size_y,
    input  logic [5:0]          size_z,
    input  logic                stencil_select,
    input  logic                boundary_mode,
    output ig3d_pkg::stat_t     stat,
    output ig3d_pkg::out_item_t result,
    output logic                done
);
    import ig3d_pkg::*;

    logic [5:0] nx_reg, ny_reg, nz_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [ZW-1:0] z_reg;
    logic [XW-1:0] qx_reg;
    logic [YW-1:0] qy_reg;
    logic [ZW-1:0] qz_reg;
    logic e6_reg, wall_reg;
    logic [4:0] p_reg;
    offset_t off_reg;
    logic skip_reg;
    logic signed [AccW-1:0] gx_reg, gy_reg, gz_reg;
    out_item_t result_reg;
    logic done_reg;
    logic signed [31:0] rdata;
    logic [AddrW-1:0] addr;
    logic ram_we;

    function automatic logic [5:0] eff(input logic [5:0] r, input logic [5:0] lim);
        logic [5:0] v;
        v = (r == 6'd0) ? 6'd1 : ((r > lim) ? lim : r);
        return v;
    endfunction

    function automatic logic [5:0] wrapc(input logic [5:0] c, input logic signed [2:0] d,
                                         input logic [5:0] n);
        logic signed [7:0] s;
        s = $signed({2'b00, c}) + 8'(d);
        if (s < 0)
        begin
            s = s + $signed({2'b00, n});
        end
        if (s < 0)
        begin
            s = s + $signed({2'b00, n});
        end
        if (s >= $signed({2'b00, n}))
        begin
            s = s - $signed({2'b00, n});
        end
        if (s >= $signed({2'b00, n}))
        begin
            s = s - $signed({2'b00, n});
        end
        return s[5:0];
    endfunction

    function automatic logic [5:0] modc(input logic [4:0] c, input logic [5:0] n);
        logic [10:0] v;
        logic [10:0] d;
        v = {6'd0, c};
        for (int i = 4; i >= 0; i--)
        begin
            d = {5'd0, n} << i;
            if (v >= d)
            begin
                v = v - d;
            end
        end
        return v[5:0];
    endfunction

    function automatic logic [31:0] rnd_sat(input logic signed [AccW-1:0] s);
        logic signed [AccW-1:0] r;
        r = (s + (AccW'(1) <<< 23)) >>> 24;
        if (r > AccW'(32'sh7fffffff))
        begin
            r = AccW'(32'sh7fffffff);
        end
        else if (r < -AccW'(64'sd2147483648))
        begin
            r = -AccW'(64'sd2147483648);
        end
        return r[31:0];
    endfunction

    function automatic logic signed [AccW-1:0] scale(input logic signed [AccW-1:0] t,
                                                     input logic signed [2:0] d);
        logic signed [AccW-1:0] v;
        case (d)
            3'sd1:   v = t;
            -3'sd1:  v = -t;
            3'sd2:   v = t <<< 1;
            -3'sd2:  v = -(t <<< 1);
            default: v = '0;
        endcase
        return v;
    endfunction

    logic signed [6:0] yy_s;
    logic [5:0] xx, yy, zz;
    offset_t off_cur;

    always_comb
    begin
        off_cur = stencil_offset(p_reg);
        xx = wrapc({1'b0, qx_reg}, off_cur.dx, nx_reg);
        zz = wrapc({1'b0, qz_reg}, off_cur.dz, nz_reg);
        yy_s = $signed({2'b00, qy_reg}) + 7'(off_cur.dy);
        yy = wall_reg ? yy_s[5:0] : wrapc({1'b0, qy_reg}, off_cur.dy, ny_reg);
    end

    assign ram_we = cmd.load && item.operation == OpWrite;
    assign addr = ram_we ? {item.cell_x, item.cell_y, item.cell_z}
                : cmd.issue ? {xx[XW-1:0], yy[YW-1:0], zz[ZW-1:0]}
                : {x_reg, y_reg, z_reg};

    ig3d_ram #(.Width(32), .Depth(Depth)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr),
        .wdata (item.cell_value),
        .rdata (rdata)
    );

    logic signed [55:0] term;
    logic signed [AccW-1:0] t2;
    always_comb
    begin
        term = $signed({1'b0, shell_weight(e6_reg, off_reg.shell)}) * rdata;
        t2 = skip_reg ? '0 : AccW'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nx_reg <= eff(size_x, 6'(DimX));
            ny_reg <= eff(size_y, 6'(DimY));
            nz_reg <= eff(size_z, 6'(DimZ));
            e6_reg <= stencil_select;
            wall_reg <= boundary_mode;
            x_reg <= item.cell_x;
            y_reg <= item.cell_y;
            z_reg <= item.cell_z;
        end
        if (cmd.clear)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
            gz_reg <= '0;
            p_reg <= '0;
        end
        if (cmd.prep)
        begin
            qx_reg <= XW'(modc(x_reg, nx_reg));
            qy_reg <= YW'(modc(y_reg, ny_reg));
            qz_reg <= ZW'(modc(z_reg, nz_reg));
        end
        if (cmd.issue)
        begin
            x_reg <= xx[XW-1:0];
            y_reg <= yy[YW-1:0];
            z_reg <= zz[ZW-1:0];
            off_reg <= off_cur;
            skip_reg <= wall_reg && (yy_s < 0 || yy_s >= $signed({1'b0, ny_reg}));
        end
        if (cmd.acc)
        begin
            gx_reg <= gx_reg + scale(t2, off_reg.dx);
            gy_reg <= gy_reg + scale(t2, off_reg.dy);
            gz_reg <= gz_reg + scale(t2, off_reg.dz);
            p_reg <= p_reg + 5'd1;
        end
        if (cmd.finish)
        begin
            result_reg.gradient_x <= rnd_sat(gx_reg);
            result_reg.gradient_y <= rnd_sat(gy_reg);
            result_reg.gradient_z <= rnd_sat(gz_reg);
        end
    end

    assign stat.last = e6_reg ? (p_reg == 5'(E6Count - 1)) : (p_reg == 5'(E4Count - 1));
    assign result = result_reg;
    assign done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done)
        else $error("result strobe missing");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("strobe longer than one cycle");
endmodule

// ===== rtl/core/isotropic_gradient_3d_top.sv =====
// Top level of the 3D isotropic gradient block: config registers, controller
// and datapath. Depends on ig3d_pkg, ig3d_ctrl, ig3d_datapath.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------
//  command  | start / busy      | cmd (in_item_t)
//  result   | done (1 cycle)    | result (out_item_t)
//  config   | cfg_we            | cfg_index, cfg_data
//
// A write is done in the idle state. A query steps through N stencil offsets (N = 18
// for E4, 32 for E6): each offset has an address state and then an accumulate state
// that uses the data from the store's registered read port. done is registered from
// the DONE state and pulses in the first cycle with busy low. Reset clears control
// and config; the field store holds garbage until written. The receiver cannot stall.
module isotropic_gradient_3d_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ig3d_pkg::in_item_t  cmd,
    output logic                busy,
    output logic                done,
    output ig3d_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [5:0]          cfg_data
);
    import ig3d_pkg::*;

    logic [5:0] size_x_reg, size_y_reg, size_z_reg;
    logic stencil_reg, boundary_reg;
    cmd_t ctl;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
            stencil_reg <= 1'b0;
            boundary_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegSizeX:    size_x_reg <= cfg_data;
                RegSizeY:    size_y_reg <= cfg_data;
                RegSizeZ:    size_z_reg <= cfg_data;
                RegStencil:  stencil_reg <= cfg_data[0];
                RegBoundary: boundary_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    ig3d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .stat      (stat),
        .cmd       (ctl),
        .busy      (busy)
    );

    ig3d_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl),
        .item           (cmd),
        .size_x         (size_x_reg),
        .size_y         (size_y_reg),
        .size_z         (size_z_reg),
        .stencil_select (stencil_reg),
        .boundary_mode  (boundary_reg),
        .stat           (stat),
        .result         (result),
        .done           (done)
    );
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for isotropic_gradient_3d_top: drives write and query items, predicts each
// gradient from its own copy of the field store and config, and checks every result.
// Depends on ig3d_pkg and the RTL of isotropic_gradient_3d_top.
module tb;
    import ig3d_pkg::*;

    localparam int NumOffsets = 32;
    localparam int OffDx[NumOffsets] = '{1, -1, 0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1, 0, 0,
                                         0, 0, 1, 1, 1, 1, -1, -1, -1, -1, 2, -2, 0, 0, 0, 0};
    localparam int OffDy[NumOffsets] = '{0, 0, 1, -1, 0, 0, 1, -1, 1, -1, 0, 0, 0, 0, 1, 1,
                                         -1, -1, 1, 1, -1, -1, 1, 1, -1, -1, 0, 0, 2, -2, 0, 0};
    localparam int OffDz[NumOffsets] = '{0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, -1,
                                         1, -1, 1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0, 2, -2};
    localparam int OffShell[NumOffsets] = '{0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                                            1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3};
    localparam longint WeightE4[4] = '{2796203, 1398101, 0, 0};
    localparam longint WeightE6[4] = '{2236962, 1118481, 279620, 139810};

    class gradient_scoreboard;
        logic signed [31:0] cells[Depth];
        logic [5:0] dims[3];
        logic use_e6;
        logic walls;
        out_item_t gradients_due[$];
        int mismatches;

        function new();
            dims = '{6'd32, 6'd32, 6'd32};
            use_e6 = 1'b0;
            walls = 1'b0;
            mismatches = 0;
        endfunction

        function int span(int axis);
            if (dims[axis] == 0)
                return 1;
            return (dims[axis] > 32) ? 32 : int'(dims[axis]);
        endfunction

        function void set_reg(logic [2:0] idx, logic [5:0] data);
            case (idx)
                RegSizeX: dims[0] = data;
                RegSizeY: dims[1] = data;
                RegSizeZ: dims[2] = data;
                RegStencil: use_e6 = data[0];
                RegBoundary: walls = data[0];
                default: ;
            endcase
        endfunction

        function void stencil_cells(int x, int y, int z, ref int addrs[$], ref int offs[$]);
            int nx, ny, nz, cnt, xx, yy, zz;
            nx = span(0);
            ny = span(1);
            nz = span(2);
            cnt = use_e6 ? E6Count : E4Count;
            x = x % nx;
            y = y % ny;
            z = z % nz;
            addrs.delete();
            offs.delete();
            for (int p = 0; p < cnt; p++)
            begin
                yy = y + OffDy[p];
                if (walls)
                begin
                    if (yy < 0 || yy >= ny)
                        continue;
                end
                else
                    yy = (yy + 2 * ny) % ny;
                xx = (x + OffDx[p] + 2 * nx) % nx;
                zz = (z + OffDz[p] + 2 * nz) % nz;
                addrs.push_back((xx * DimY + yy) * DimZ + zz);
                offs.push_back(p);
            end
        endfunction

        function logic signed [31:0] round_q24(longint s);
            longint r;
            r = (s + (64'sd1 <<< 23)) >>> 24;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_item(in_item_t it);
            int addrs[$], offs[$];
            longint gx, gy, gz, term;
            out_item_t g;
            if (it.operation == OpWrite)
            begin
                cells[(int'(it.cell_x) * DimY + int'(it.cell_y)) * DimZ + int'(it.cell_z)] =
                    it.cell_value;
                return;
            end
            stencil_cells(it.cell_x, it.cell_y, it.cell_z, addrs, offs);
            gx = 0;
            gy = 0;
            gz = 0;
            foreach (addrs[i])
            begin
                term = (use_e6 ? WeightE6[OffShell[offs[i]]] : WeightE4[OffShell[offs[i]]])
                       * longint'(cells[addrs[i]]);
                gx += term * OffDx[offs[i]];
                gy += term * OffDy[offs[i]];
                gz += term * OffDz[offs[i]];
            end
            g.gradient_x = round_q24(gx);
            g.gradient_y = round_q24(gy);
            g.gradient_z = round_q24(gz);
            gradients_due.push_back(g);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (gradients_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected gradient %h", got);
                return;
            end
            want = gradients_due.pop_front();
            if (got.gradient_x !== want.gradient_x || got.gradient_y !== want.gradient_y ||
                got.gradient_z !== want.gradient_z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: gradient mismatch exp %h %h %h got %h %h %h",
                             want.gradient_x, want.gradient_y, want.gradient_z,
                             got.gradient_x, got.gradient_y, got.gradient_z);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    in_item_t cmd;
    logic busy;
    logic done;
    out_item_t result;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [5:0] cfg_data;

    gradient_scoreboard sb;
    bit written[Depth];
    int items_sent;
    bit quiet;

    isotropic_gradient_3d_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 27)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        if (it.operation == OpWrite)
            written[(int'(it.cell_x) * DimY + int'(it.cell_y)) * DimZ + int'(it.cell_z)] = 1'b1;
        items_sent++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(512))) - 256;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_cell(int addr, logic signed [31:0] v);
        in_item_t it;
        it.operation = OpWrite;
        it.cell_x = 5'(addr / (DimY * DimZ));
        it.cell_y = 5'((addr / DimZ) % DimY);
        it.cell_z = 5'(addr % DimZ);
        it.cell_value = v;
        send_item(it);
    endtask

    // extreme: full-scale neighbor values signed by offset sum; zero sum gets random
    task automatic query_at(int x, int y, int z, bit extreme);
        int addrs[$], offs[$], s;
        in_item_t it;
        sb.stencil_cells(x, y, z, addrs, offs);
        foreach (addrs[i])
        begin
            s = OffDx[offs[i]] + OffDy[offs[i]] + OffDz[offs[i]];
            if (extreme)
                write_cell(addrs[i], (s > 0) ? 32'sh7fffffff :
                                     (s < 0) ? 32'sh80000000 : pick_value());
            else if (!written[addrs[i]])
                write_cell(addrs[i], pick_value());
        end
        it.operation = OpQuery;
        it.cell_x = 5'(x);
        it.cell_y = 5'(y);
        it.cell_z = 5'(z);
        it.cell_value = $urandom;
        send_item(it);
    endtask

    task automatic set_config(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz,
                              logic st, logic bd);
        logic [5:0] vals[5];
        vals = '{sx, sy, sz, {5'd0, st}, {5'd0, bd}};
        @(negedge clk);
        start <= 1'b0;
        while (sb.gradients_due.size() != 0 || busy)
            @(negedge clk);
        repeat (100) @(negedge clk);
        for (int r = 0; r < 5; r++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(r);
            cfg_data <= vals[r];
            sb.set_reg(3'(r), vals[r]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [5:0] phase_dims[8][3];
        logic phase_st[8];
        logic phase_bd[8];
        in_item_t it;
        int phase_end;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        quiet = 1'b0;
        phase_dims = '{'{6'd32, 6'd32, 6'd32}, '{6'd1, 6'd1, 6'd1}, '{6'd0, 6'd63, 6'd2},
                       '{6'd32, 6'd32, 6'd32}, '{6'd3, 6'd1, 6'd5}, '{6'd5, 6'd2, 6'd32},
                       '{6'd4, 6'd7, 6'd3}, '{6'd2, 6'd32, 6'd6}};
        phase_st = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_bd = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        query_at(0, 0, 0, 1'b1);
        query_at(31, 31, 31, 1'b0);

        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(phase_dims[ph][0], phase_dims[ph][1], phase_dims[ph][2],
                       phase_st[ph], phase_bd[ph]);
            if (ph == 3)
                query_at(0, 31, 0, 1'b1);
            phase_end = items_sent + 215;
            while (items_sent < phase_end)
            begin
                quiet = (ph == 4);
                if ($urandom_range(99) < 12)
                begin
                    it.operation = OpWrite;
                    it.cell_x = 5'($urandom);
                    it.cell_y = 5'($urandom);
                    it.cell_z = 5'($urandom);
                    it.cell_value = pick_value();
                    send_item(it);
                end
                else
                    query_at($urandom_range(31), $urandom_range(31), $urandom_range(31),
                             $urandom_range(9) == 0);
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        start <= 1'b0;
        while (sb.gradients_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
